/* design/assert_macros.svh */
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/sol_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package sol_pkg;

    // field widths
    localparam int MODE_W    = 2;
    localparam int ADDR_F_W  = 12;
    localparam int PERM_W    = 13;
    localparam int COUNT_W   = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 13;
    localparam int S_DATA_W  = 32;
    localparam int M_DATA_W  = 24;

    // fixed point 1.0 and count ceiling
    localparam int PERM_ONE     = 4096;
    localparam int MAX_SYNAPSES = 64;
    localparam int COUNT_LIMIT  = (MAX_SYNAPSES > 127) ? 127 : MAX_SYNAPSES;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD     = 2'd0,
        MODE_ACTIVITY = 2'd1,
        MODE_LEARN    = 2'd2
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CONNECTED = 2'd0,
        REG_THRESHOLD = 2'd1,
        REG_INCREMENT = 2'd2,
        REG_DECREMENT = 2'd3
    } reg_idx_t;

    localparam logic KIND_OVERLAP    = 1'b0;
    localparam logic KIND_PERMANENCE = 1'b1;

endpackage
`default_nettype wire

/* design/sol_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module sol_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  wire                      clk,
    input  wire                      we,
    input  wire  [$clog2(DEPTH)-1:0] waddr,
    input  wire  [WIDTH-1:0]         wdata,
    input  wire                      re,
    input  wire  [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port; rdata holds when not reading
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

/* design/synapse_overlap_and_learn.sv */
`timescale 1ns / 1ps
`default_nettype none
// Synapse overlap and permanence learning.
// Input stream s_*: one word per item; tuser carries the mode (load bit,
// activity synapse, learn synapse), tlast marks the last synapse slot of a cell.
// Load words write one bit of the input bitmap and give no result. Activity
// words accumulate a per-cell count and give an overlap word on the last slot.
// Learn words give one updated permanence word each.
// Result stream m_*: tuser is the result kind (0 overlap, 1 permanence).
// Path: an accepted word's bitmap read and fields are registered into the compute
// stage, then its result is computed into the output register.
// Throughput: one word per cycle when not stalled; the bitmap RAM takes one read
// or one write per accepted word, in arrival order, so no forwarding is needed.
// Stall: when m_tready is low the output register holds, one more word may
// sit in the compute stage, then s_tready drops.
// Reset: synchronous, aresetn low. Config registers and cell state clear, then
// the bitmap is swept to zero, one address after another, with s_tready held low.
// Config writes (cfg_wr_en, cfg_index, cfg_data) are taken at any time out of reset.
module synapse_overlap_and_learn #(
    parameter int INPUT_BITS = 4096
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    // config write port
    input  wire                               cfg_wr_en,
    input  wire  [sol_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [sol_pkg::CFG_W-1:0]         cfg_data,
    // input stream
    input  wire                               s_tvalid,
    output logic                              s_tready,
    // tdata: bit_address[11:0], bit_value[12], unconnected[13],
    //        permanence[26:14], learn_cell[27], zero[31:28]
    input  wire  [sol_pkg::S_DATA_W-1:0]      s_tdata,
    // tuser: mode[1:0]
    input  wire  [sol_pkg::MODE_W-1:0]        s_tuser,
    input  wire                               s_tlast,
    // result stream
    output logic                              m_tvalid,
    input  wire                               m_tready,
    // tdata: overlap[6:0], new_permanence[19:7], zero[23:20]
    output logic [sol_pkg::M_DATA_W-1:0]      m_tdata,
    // tuser: result_kind[0]
    output logic [0:0]                        m_tuser
);

    import sol_pkg::*;

    `include "assert_macros.svh"

    localparam int ADDR_W = (INPUT_BITS > 1) ? $clog2(INPUT_BITS) : 1;
    localparam int EXT_W  = ((ADDR_W > ADDR_F_W) ? ADDR_W : ADDR_F_W) + 1;

    // config registers
    logic [PERM_W-1:0]  conn_reg;
    logic [COUNT_W-1:0] thr_reg;
    logic [PERM_W-1:0]  inc_reg;
    logic [PERM_W-1:0]  dec_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            conn_reg <= '0;
            thr_reg  <= '0;
            inc_reg  <= '0;
            dec_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (reg_idx_t'(cfg_index))
                REG_CONNECTED: conn_reg <= cfg_data;
                REG_THRESHOLD: thr_reg  <= cfg_data[COUNT_W-1:0];
                REG_INCREMENT: inc_reg  <= cfg_data;
                REG_DECREMENT: dec_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // input word unpacking
    logic [ADDR_F_W-1:0] in_addr;
    logic                in_bit;
    logic                in_unconn;
    logic [PERM_W-1:0]   in_perm;
    logic                in_learn;
    logic [EXT_W-1:0]    in_addr_ext;
    logic                in_range;

    assign in_addr     = s_tdata[11:0];
    assign in_bit      = s_tdata[12];
    assign in_unconn   = s_tdata[13];
    assign in_perm     = s_tdata[26:14];
    assign in_learn    = s_tdata[27];
    assign in_addr_ext = EXT_W'(in_addr);
    assign in_range    = (in_addr_ext < EXT_W'(INPUT_BITS));

    // bitmap clearing sweep after reset
    logic              clr_busy_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end else if (clr_busy_reg) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == ADDR_W'(INPUT_BITS - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // handshake and pipeline control
    logic s_acc;
    logic in_synapse;
    logic in_load;
    logic out_free;
    logic p1_adv;
    logic p1_valid_reg;
    logic p1_valid_next;

    assign in_synapse = (mode_t'(s_tuser) == MODE_ACTIVITY) || (mode_t'(s_tuser) == MODE_LEARN);
    assign in_load    = (mode_t'(s_tuser) == MODE_LOAD);
    assign out_free   = !m_tvalid || m_tready;
    assign p1_adv     = p1_valid_reg && out_free;
    assign s_tready   = !clr_busy_reg && (!p1_valid_reg || out_free);
    assign s_acc      = s_tvalid && s_tready;

    // bitmap RAM: writes and reads issue at acceptance, so they stay in order
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic              ram_wdata;
    logic              ram_re;
    logic              ram_rdata;

    assign ram_we    = clr_busy_reg || (s_acc && in_load && in_range);
    assign ram_waddr = clr_busy_reg ? clr_cnt_reg : in_addr_ext[ADDR_W-1:0];
    assign ram_wdata = clr_busy_reg ? 1'b0 : in_bit;
    assign ram_re    = s_acc && in_synapse;

    sol_ram #(
        .WIDTH (1),
        .DEPTH (INPUT_BITS)
    ) u_bitmap (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (in_addr_ext[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // compute stage: synapse waiting for its bitmap read
    typedef struct packed {
        logic              learn_mode;
        logic              in_range;
        logic              unconn;
        logic [PERM_W-1:0] perm;
        logic              learn;
        logic              last;
    } stage_t;

    stage_t p1_reg;

    always_comb begin
        p1_valid_next = p1_valid_reg;
        if (ram_re) begin
            p1_valid_next = 1'b1;
        end else if (p1_adv) begin
            p1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= p1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ram_re) begin
            p1_reg.learn_mode <= (mode_t'(s_tuser) == MODE_LEARN);
            p1_reg.in_range   <= in_range;
            p1_reg.unconn     <= in_unconn;
            p1_reg.perm       <= in_perm;
            p1_reg.learn      <= in_learn;
            p1_reg.last       <= s_tlast;
        end
    end

    // cell state
    logic [COUNT_W-1:0] cnt_reg;
    logic [COUNT_W-1:0] cnt_next;
    logic               ended_reg;
    logic               ended_next;

    // result computation
    logic               tgt_bit;
    logic               ended_now;
    logic               hit;
    logic [COUNT_W-1:0] cnt_upd;
    logic [PERM_W:0]    perm_up;
    logic [PERM_W:0]    perm_lrn;
    logic [PERM_W-1:0]  perm_out;
    logic [COUNT_W-1:0] ovl_out;
    logic               emit;

    always_comb begin
        tgt_bit   = p1_reg.in_range && ram_rdata;
        ended_now = ended_reg || p1_reg.unconn;
        hit       = !ended_now && tgt_bit && (p1_reg.perm > conn_reg);
        cnt_upd   = (hit && (cnt_reg < COUNT_W'(COUNT_LIMIT))) ? cnt_reg + 1'b1 : cnt_reg;

        // learning: up by increment or down by decrement, clamped to [0, 1.0]
        perm_up = tgt_bit ? ({1'b0, p1_reg.perm} + {1'b0, inc_reg})
                          : ((p1_reg.perm < dec_reg) ? '0
                                                     : {1'b0, p1_reg.perm - dec_reg});
        perm_lrn = (perm_up > (PERM_W + 1)'(PERM_ONE)) ? (PERM_W + 1)'(PERM_ONE) : perm_up;
        perm_out = (!ended_now && p1_reg.learn) ? perm_lrn[PERM_W-1:0] : p1_reg.perm;

        ovl_out = (cnt_upd >= thr_reg) ? cnt_upd : '0;
        emit    = p1_reg.learn_mode || p1_reg.last;

        cnt_next   = cnt_reg;
        ended_next = ended_reg;
        if (p1_adv) begin
            if (p1_reg.last) begin
                cnt_next   = '0;
                ended_next = 1'b0;
            end else begin
                cnt_next   = p1_reg.learn_mode ? cnt_reg : cnt_upd;
                ended_next = ended_now;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            ended_reg <= 1'b0;
        end else begin
            cnt_reg   <= cnt_next;
            ended_reg <= ended_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else if (p1_adv && emit) begin
            m_tvalid <= 1'b1;
        end else if (m_tready) begin
            m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_adv && emit) begin
            if (p1_reg.learn_mode) begin
                m_tdata <= {4'b0, perm_out, {COUNT_W{1'b0}}};
                m_tuser <= KIND_PERMANENCE;
            end else begin
                m_tdata <= {4'b0, {PERM_W{1'b0}}, ovl_out};
                m_tuser <= KIND_OVERLAP;
            end
        end
    end

    // checks
    `ASSERT_SAME(a_no_accept_in_sweep, aclk, aresetn, clr_busy_reg, !s_tready,
        "word accepted during bitmap sweep")
    `ASSERT_SAME(a_no_accept_on_stall, aclk, aresetn, p1_valid_reg && !out_free, !s_acc,
        "word accepted while compute stage is stalled")
    `ASSERT_SAME(a_count_limit, aclk, aresetn, 1'b1, cnt_reg <= COUNT_W'(COUNT_LIMIT),
        "cell count beyond its limit")
    `ASSERT_NEXT(a_result_source, aclk, aresetn, !m_tvalid && !(p1_adv && emit), !m_tvalid,
        "result word without a compute stage source")

endmodule
`default_nettype wire
